// File: design/kis_pkg.sv
package kis_pkg;

    localparam int KIS_WORD_BITS = 64;
    localparam int KIS_ROUNDS    = 8;
    localparam int KIS_SEL_BITS  = 32;
    localparam logic [3:0] KIS_RC_RESET = 4'd4;
    localparam logic [3:0] KIS_RC_MAX   = 4'd8;

    typedef enum logic [3:0] {
        OP_XOR_KEY    = 4'd0,
        OP_NEG        = 4'd1,
        OP_ROTL_PLUS  = 4'd2,
        OP_BSWAP      = 4'd3,
        OP_NOT        = 4'd4,
        OP_ROTR_MINUS = 4'd5,
        OP_ADD_KEY    = 4'd6,
        OP_SUB_KEY    = 4'd7,
        OP_HALF_XOR   = 4'd8,
        OP_XOR_PLUS   = 4'd9,
        OP_XOR_NKEY   = 4'd10,
        OP_XOR_MINUS  = 4'd11,
        OP_XOR_PROD   = 4'd12,
        OP_ADD_POS    = 4'd13,
        OP_SUB_POS    = 4'd14,
        OP_ROTL_KEY   = 4'd15
    } t_op;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic [KIS_SEL_BITS-1:0] sels;
    } t_ctl;

endpackage

// File: design/kis_prep.sv
module kis_prep #(
    parameter int W  = kis_pkg::KIS_WORD_BITS,
    parameter int AW = $clog2(W)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  logic [63:0]   i_index_value,
    input  logic [63:0]   i_entry_key,
    input  logic [31:0]   i_table_position,
    output kis_pkg::t_ctl o_ctl,
    output logic [W-1:0]  o_x,
    output logic [W-1:0]  o_kw,
    output logic [W-1:0]  o_pw,
    output logic [W-1:0]  o_plus,
    output logic [W-1:0]  o_minus,
    output logic [W-1:0]  o_prod,
    output logic [AW-1:0] o_amt_plus,
    output logic [AW-1:0] o_amt_minus,
    output logic [AW-1:0] o_amt_key
);
    import kis_pkg::*;

    localparam int NM = 4;
    localparam logic [AW:0] WMOD = (AW+1)'(W);

    // Residue of a 32-bit rotate amount modulo W, eight bits per stage.
    function automatic logic [AW-1:0] f_mod_byte(input logic [AW-1:0] r, input logic [7:0] b);
        logic [AW:0] t;
        t = {1'b0, r};
        for (int i = 7; i >= 0; i--) begin
            t = {t[AW-1:0], b[i]};
            if (t >= WMOD) begin
                t = t - WMOD;
            end
        end
        return t[AW-1:0];
    endfunction

    t_ctl         r_ctl   [NM+1];
    logic [W-1:0] r_x     [NM+1];
    logic [W-1:0] r_kw    [NM+1];
    logic [W-1:0] r_pw    [NM+1];
    logic [W-1:0] r_plus  [NM+1];
    logic [W-1:0] r_minus [NM+1];
    logic [W-1:0] r_prod  [NM];
    logic [31:0]  r_src   [NM][3];
    logic [AW-1:0] r_res  [NM][3];
    logic [63:0]  r_pl;
    logic [31:0]  r_ph;

    t_ctl        n_ctl;
    logic [63:0] n_plus;
    logic [63:0] n_minus;
    logic [63:0] n_pl;
    logic [63:0] n_ph;
    logic [63:0] n_sum;

    always_comb begin
        n_ctl.valid = i_in_valid;
        n_ctl.kind  = i_kind;
        n_ctl.sels  = i_entry_key[63:32];
        n_plus  = i_entry_key + {32'd0, i_table_position};
        n_minus = i_entry_key - {32'd0, i_table_position};
        n_pl    = i_entry_key[31:0] * i_table_position;
        n_ph    = i_entry_key[63:32] * i_table_position;
        n_sum   = r_pl + {r_ph, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_adv) begin
            r_ctl[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0]     <= i_index_value[W-1:0];
            r_kw[0]    <= i_entry_key[W-1:0];
            r_pw[0]    <= W'({32'd0, i_table_position});
            r_plus[0]  <= n_plus[W-1:0];
            r_minus[0] <= n_minus[W-1:0];
            r_src[0][0] <= n_plus[31:0];
            r_src[0][1] <= n_minus[31:0];
            r_src[0][2] <= i_entry_key[31:0];
            r_pl       <= n_pl;
            r_ph       <= n_ph[31:0];
        end
    end

    for (genvar g = 1; g <= NM; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_adv) begin
                r_ctl[g] <= r_ctl[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[g]     <= r_x[g-1];
                r_kw[g]    <= r_kw[g-1];
                r_pw[g]    <= r_pw[g-1];
                r_plus[g]  <= r_plus[g-1];
                r_minus[g] <= r_minus[g-1];
            end
        end

        if (g == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_prod[0] <= n_sum[W-1:0];
                    for (int c = 0; c < 3; c++) begin
                        r_res[0][c] <= f_mod_byte('0, r_src[0][c][31:24]);
                    end
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_prod[g-1] <= r_prod[g-2];
                    for (int c = 0; c < 3; c++) begin
                        r_res[g-1][c] <= f_mod_byte(r_res[g-2][c],
                                                    r_src[g-1][c][31-8*(g-1) -: 8]);
                    end
                end
            end
        end

        if (g < NM) begin : g_src
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    for (int c = 0; c < 3; c++) begin
                        r_src[g][c] <= r_src[g-1][c];
                    end
                end
            end
        end
    end

    assign o_ctl       = r_ctl[NM];
    assign o_x         = r_x[NM];
    assign o_kw        = r_kw[NM];
    assign o_pw        = r_pw[NM];
    assign o_plus      = r_plus[NM];
    assign o_minus     = r_minus[NM];
    assign o_prod      = r_prod[NM-1];
    assign o_amt_plus  = r_res[NM-1][0];
    assign o_amt_minus = r_res[NM-1][1];
    assign o_amt_key   = r_res[NM-1][2];

endmodule

// File: design/kis_round.sv
module kis_round #(
    parameter int W  = kis_pkg::KIS_WORD_BITS,
    parameter int AW = $clog2(W)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_active,
    input  kis_pkg::t_op  i_sel,
    input  kis_pkg::t_ctl i_ctl,
    input  logic [W-1:0]  i_x,
    input  logic [W-1:0]  i_kw,
    input  logic [W-1:0]  i_pw,
    input  logic [W-1:0]  i_plus,
    input  logic [W-1:0]  i_minus,
    input  logic [W-1:0]  i_prod,
    input  logic [AW-1:0] i_amt_plus,
    input  logic [AW-1:0] i_amt_minus,
    input  logic [AW-1:0] i_amt_key,
    output kis_pkg::t_ctl o_ctl,
    output logic [W-1:0]  o_x,
    output logic [W-1:0]  o_kw,
    output logic [W-1:0]  o_pw,
    output logic [W-1:0]  o_plus,
    output logic [W-1:0]  o_minus,
    output logic [W-1:0]  o_prod,
    output logic [AW-1:0] o_amt_plus,
    output logic [AW-1:0] o_amt_minus,
    output logic [AW-1:0] o_amt_key
);
    import kis_pkg::*;

    localparam int  NB   = W / 8;
    localparam bit  BSW  = (W % 8) == 0;
    localparam int  HALF = W / 2;
    localparam logic [AW:0] WAMT = (AW+1)'(W);

    function automatic logic [W-1:0] f_rotl(input logic [W-1:0] x, input logic [AW-1:0] a);
        logic [AW:0] ra;
        ra = WAMT - {1'b0, a};
        return (x << a) | (x >> ra);
    endfunction

    function automatic logic [W-1:0] f_rotr(input logic [W-1:0] x, input logic [AW-1:0] a);
        logic [AW:0] ra;
        ra = WAMT - {1'b0, a};
        return (x >> a) | (x << ra);
    endfunction

    function automatic logic [W-1:0] f_bswap(input logic [W-1:0] x);
        logic [W-1:0] r;
        r = x;
        if (BSW) begin
            for (int i = 0; i < NB; i++) begin
                r[8*(NB-1-i) +: 8] = x[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [W-1:0] f_half(input logic [W-1:0] x);
        logic [W-1:0] r;
        r = '0;
        r[2*HALF-1:HALF] = x[2*HALF-1:HALF];
        r[HALF-1:0]      = x[2*HALF-1:HALF] ^ x[HALF-1:0];
        return r;
    endfunction

    t_ctl          r_ctl;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_kw;
    logic [W-1:0]  r_pw;
    logic [W-1:0]  r_plus;
    logic [W-1:0]  r_minus;
    logic [W-1:0]  r_prod;
    logic [AW-1:0] r_amt_plus;
    logic [AW-1:0] r_amt_minus;
    logic [AW-1:0] r_amt_key;

    logic [W-1:0]  n_x;
    logic [W-1:0]  w_op;
    logic          w_inv;

    assign w_inv = i_ctl.kind;

    always_comb begin
        unique case (i_sel)
            OP_XOR_KEY:    w_op = i_x ^ i_kw;
            OP_NEG:        w_op = '0 - i_x;
            OP_ROTL_PLUS:  w_op = w_inv ? f_rotr(i_x, i_amt_plus) : f_rotl(i_x, i_amt_plus);
            OP_BSWAP:      w_op = f_bswap(i_x);
            OP_NOT:        w_op = ~i_x;
            OP_ROTR_MINUS: w_op = w_inv ? f_rotl(i_x, i_amt_minus) : f_rotr(i_x, i_amt_minus);
            OP_ADD_KEY:    w_op = w_inv ? i_x - i_kw : i_x + i_kw;
            OP_SUB_KEY:    w_op = w_inv ? i_x + i_kw : i_x - i_kw;
            OP_HALF_XOR:   w_op = f_half(i_x);
            OP_XOR_PLUS:   w_op = i_x ^ i_plus;
            OP_XOR_NKEY:   w_op = i_x ^ ~i_kw;
            OP_XOR_MINUS:  w_op = i_x ^ i_minus;
            OP_XOR_PROD:   w_op = i_x ^ i_prod;
            OP_ADD_POS:    w_op = w_inv ? i_x - i_pw : i_x + i_pw;
            OP_SUB_POS:    w_op = w_inv ? i_x + i_pw : i_x - i_pw;
            OP_ROTL_KEY:   w_op = w_inv ? f_rotr(i_x, i_amt_key) : f_rotl(i_x, i_amt_key);
        endcase
        n_x = i_active ? w_op : i_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x         <= n_x;
            r_kw        <= i_kw;
            r_pw        <= i_pw;
            r_plus      <= i_plus;
            r_minus     <= i_minus;
            r_prod      <= i_prod;
            r_amt_plus  <= i_amt_plus;
            r_amt_minus <= i_amt_minus;
            r_amt_key   <= i_amt_key;
        end
    end

    assign o_ctl       = r_ctl;
    assign o_x         = r_x;
    assign o_kw        = r_kw;
    assign o_pw        = r_pw;
    assign o_plus      = r_plus;
    assign o_minus     = r_minus;
    assign o_prod      = r_prod;
    assign o_amt_plus  = r_amt_plus;
    assign o_amt_minus = r_amt_minus;
    assign o_amt_key   = r_amt_key;

endmodule

// File: design/keyed_index_scrambler_unit.sv
// Pipeline: an input transfer passes the operand and rotate-amount stages, then
// the 8 round stages.
// Throughput: one item per cycle; a stalled output holds every stage in place.
// Reset (i_rst_n low at a clock edge) clears all valid bits and sets the round
// count to four.
module keyed_index_scrambler_unit #(
    parameter int WORD_BITS = kis_pkg::KIS_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [63:0] i_index_value,
    input  logic [63:0] i_entry_key,
    input  logic [31:0] i_table_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_scrambled_value
);
    import kis_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int AW = $clog2(W);
    localparam int NR = KIS_ROUNDS;

    logic [3:0] r_round_count;
    logic [3:0] w_n;
    logic       w_adv;

    t_ctl          w_ctl       [NR+1];
    logic [W-1:0]  w_x         [NR+1];
    logic [W-1:0]  w_kw        [NR+1];
    logic [W-1:0]  w_pw        [NR+1];
    logic [W-1:0]  w_plus      [NR+1];
    logic [W-1:0]  w_minus     [NR+1];
    logic [W-1:0]  w_prod      [NR+1];
    logic [AW-1:0] w_amt_plus  [NR+1];
    logic [AW-1:0] w_amt_minus [NR+1];
    logic [AW-1:0] w_amt_key   [NR+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= KIS_RC_RESET;
        end else if (i_cfg_we) begin
            r_round_count <= i_cfg_wdata;
        end
    end

    assign w_n        = (r_round_count > KIS_RC_MAX) ? KIS_RC_MAX : r_round_count;
    assign w_adv      = !w_ctl[NR].valid || i_out_ready;
    assign o_in_ready = w_adv;

    kis_prep #(
        .W  (W),
        .AW (AW)
    ) u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_in_valid       (i_in_valid),
        .i_kind           (i_kind),
        .i_index_value    (i_index_value),
        .i_entry_key      (i_entry_key),
        .i_table_position (i_table_position),
        .o_ctl            (w_ctl[0]),
        .o_x              (w_x[0]),
        .o_kw             (w_kw[0]),
        .o_pw             (w_pw[0]),
        .o_plus           (w_plus[0]),
        .o_minus          (w_minus[0]),
        .o_prod           (w_prod[0]),
        .o_amt_plus       (w_amt_plus[0]),
        .o_amt_minus      (w_amt_minus[0]),
        .o_amt_key        (w_amt_key[0])
    );

    for (genvar j = 0; j < NR; j++) begin : g_round
        logic       w_active;
        logic [2:0] w_idx;
        logic [3:0] w_inv_idx;
        t_op        w_sel;

        // Unscrambling walks the selector nibbles from the last active one down.
        always_comb begin
            w_active  = 4'(j) < w_n;
            w_inv_idx = w_n - 4'(j + 1);
            w_idx     = w_ctl[j].kind ? w_inv_idx[2:0] : 3'(j);
            w_sel     = t_op'(w_ctl[j].sels[{w_idx, 2'b00} +: 4]);
        end

        kis_round #(
            .W  (W),
            .AW (AW)
        ) u_round (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_active    (w_active),
            .i_sel       (w_sel),
            .i_ctl       (w_ctl[j]),
            .i_x         (w_x[j]),
            .i_kw        (w_kw[j]),
            .i_pw        (w_pw[j]),
            .i_plus      (w_plus[j]),
            .i_minus     (w_minus[j]),
            .i_prod      (w_prod[j]),
            .i_amt_plus  (w_amt_plus[j]),
            .i_amt_minus (w_amt_minus[j]),
            .i_amt_key   (w_amt_key[j]),
            .o_ctl       (w_ctl[j+1]),
            .o_x         (w_x[j+1]),
            .o_kw        (w_kw[j+1]),
            .o_pw        (w_pw[j+1]),
            .o_plus      (w_plus[j+1]),
            .o_minus     (w_minus[j+1]),
            .o_prod      (w_prod[j+1]),
            .o_amt_plus  (w_amt_plus[j+1]),
            .o_amt_minus (w_amt_minus[j+1]),
            .o_amt_key   (w_amt_key[j+1])
        );
    end

    assign o_out_valid       = w_ctl[NR].valid;
    assign o_scrambled_value = 64'(w_x[NR]);

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import kis_pkg::*;

    localparam int RESULT_LATENCY = 13;
    localparam int NUM_DIRECTED = 23;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES = 16;

    typedef struct packed {
        logic        kind;
        logic [63:0] index_value;
        logic [63:0] entry_key;
        logic [31:0] table_position;
        logic        typed;
        logic [63:0] want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [63:0] i_index_value = 64'd0;
    logic [63:0] i_entry_key = 64'd0;
    logic [31:0] i_table_position = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_scrambled_value;

    logic [63:0] pending_scrambles [$];
    logic [3:0]  round_setting = KIS_RC_RESET;
    t_row        directed_rows [NUM_DIRECTED];
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          errors = 0;
    int          transfers_in = 0;
    int          results_checked = 0;
    int          settings_used = 1;

    keyed_index_scrambler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_index_value    (i_index_value),
        .i_entry_key      (i_entry_key),
        .i_table_position (i_table_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_scrambled_value(o_scrambled_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] rot_left(logic [63:0] x, logic [5:0] amt);
        return (x << amt) | (x >> (7'd64 - amt));
    endfunction

    function automatic logic [63:0] scramble_round(t_op op, bit undo, logic [63:0] x,
                                                   logic [63:0] k, logic [31:0] p);
        logic [63:0] pw;
        logic [63:0] kp;
        logic [63:0] km;
        logic [63:0] r;
        pw = {32'd0, p};
        kp = k + pw;
        km = k - pw;
        case (op)
            OP_NEG:        r = 64'd0 - x;
            OP_ROTL_PLUS:  r = rot_left(x, undo ? 6'd0 - kp[5:0] : kp[5:0]);
            OP_BSWAP:      r = {<<8{x}};
            OP_NOT:        r = ~x;
            OP_ROTR_MINUS: r = rot_left(x, undo ? km[5:0] : 6'd0 - km[5:0]);
            OP_ADD_KEY:    r = undo ? x - k : x + k;
            OP_SUB_KEY:    r = undo ? x + k : x - k;
            OP_HALF_XOR:   r = {x[63:32], x[63:32] ^ x[31:0]};
            OP_XOR_PLUS:   r = x ^ kp;
            OP_XOR_NKEY:   r = x ^ ~k;
            OP_XOR_MINUS:  r = x ^ km;
            OP_XOR_PROD:   r = x ^ (k * pw);
            OP_ADD_POS:    r = undo ? x - pw : x + pw;
            OP_SUB_POS:    r = undo ? x + pw : x - pw;
            OP_ROTL_KEY:   r = rot_left(x, undo ? 6'd0 - k[5:0] : k[5:0]);
            default:       r = x ^ k;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] predict_scramble(logic kind, logic [63:0] x,
                                                     logic [63:0] key, logic [31:0] pos,
                                                     logic [3:0] rounds);
        int          n;
        logic [31:0] sels;
        logic [63:0] w;
        n = (rounds > KIS_RC_MAX) ? int'(KIS_RC_MAX) : int'(rounds);
        sels = key[63:32];
        w = x;
        if (!kind) begin
            for (int i = 0; i < n; i++)
                w = scramble_round(t_op'(sels[4*i +: 4]), 1'b0, w, key, pos);
        end else begin
            for (int i = n - 1; i >= 0; i--)
                w = scramble_round(t_op'(sels[4*i +: 4]), 1'b1, w, key, pos);
        end
        return w;
    endfunction

    task automatic send_item(input logic kind, input logic [63:0] idx, input logic [63:0] key,
                             input logic [31:0] pos, input logic typed,
                             input logic [63:0] want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_index_value <= idx;
        i_entry_key <= key;
        i_table_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        transfers_in++;
        pending_scrambles.insert(pending_scrambles.size(),
                                 typed ? want : predict_scramble(kind, idx, key, pos,
                                                                 round_setting));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_scrambles.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_round_count(input logic [3:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        round_setting = value;
        settings_used++;
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scrambles.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected nothing, got %h",
                         $time, o_scrambled_value);
            end else begin
                want = pending_scrambles.pop_front();
                results_checked++;
                if (want !== o_scrambled_value) begin
                    errors++;
                    $display("%0t: scrambled_value mismatch, expected %h, got %h",
                             $time, want, o_scrambled_value);
                end
            end
        end
    end

    initial begin
        int stall;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [3:0]  phase_counts [NUM_PHASES];
        logic        kind;
        logic [63:0] idx;
        logic [63:0] key;
        logic [31:0] pos;
        int          pick;

        phase_counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd2, 4'd3, 4'd5,
                         4'd6, 4'd7, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd4};

        // With the reset round count of four, rows 0 to 5 pick self-undoing operations four
        // times over and row 6 rotates an all-ones word, so the word must come back unchanged.
        directed_rows[0] = '{1'b0, 64'd0, 64'd0, 32'd0, 1'b1, 64'd0};
        directed_rows[1] = '{1'b0, '1, 64'd0, '1, 1'b1, '1};
        directed_rows[2] = '{1'b1, 64'h0123_4567_89AB_CDEF, 64'h4444_4444_FFFF_FFFF, '1,
                             1'b1, 64'h0123_4567_89AB_CDEF};
        directed_rows[3] = '{1'b0, 64'h8000_0000_0000_0001, 64'h1111_1111_0000_0000, 32'd0,
                             1'b1, 64'h8000_0000_0000_0001};
        directed_rows[4] = '{1'b1, 64'hFEDC_BA98_7654_3210, 64'h3333_3333_1234_5678,
                             32'h8000_0000, 1'b1, 64'hFEDC_BA98_7654_3210};
        directed_rows[5] = '{1'b0, 64'hDEAD_BEEF_0BAD_F00D, 64'h8888_8888_5555_AAAA,
                             32'h7FFF_FFFF, 1'b1, 64'hDEAD_BEEF_0BAD_F00D};
        directed_rows[6] = '{1'b0, '1, '1, '1, 1'b1, '1};
        for (int op = 0; op < 16; op++) begin
            directed_rows[7 + op] = '{1'(op), 64'hA5C3_0F96_1E2D_3C4B + 64'(op),
                                      {{8{4'(op)}}, 32'h9E37_79B9 ^ 32'(op * 37)},
                                      32'hC2B2_AE35 + 32'(op * 4099), 1'b0, 64'd0};
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_item(directed_rows[r].kind, directed_rows[r].index_value,
                      directed_rows[r].entry_key, directed_rows[r].table_position,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_round_count(phase_counts[ph]);
            tx_burst = (ph % 3) == 1;
            rx_burst = (ph % 4) == 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    idx = 64'd0;
                else if (pick == 1)
                    idx = '1;
                else if (pick == 2)
                    idx = 64'h8000_0000_0000_0000;
                else
                    idx = {$urandom, $urandom};
                key = {$urandom, $urandom};
                if ($urandom_range(0, 5) == 0)
                    key[63:32] = {8{4'($urandom_range(0, 15))}};
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    pos = 32'd0;
                else if (pick == 1)
                    pos = '1;
                else
                    pos = $urandom;
                send_item(kind, idx, key, pos, 1'b0, 64'd0);
            end
        end

        drain_results();
        $display("Checked %0d results against %0d input transfers across %0d round-count",
                 results_checked, transfers_in, settings_used);
        $display("settings, scrambling and unscrambling with every round operation.");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/kis_pkg.sv
design/kis_prep.sv
design/kis_round.sv
design/keyed_index_scrambler_unit.sv
verif/tb_top.sv
